### hw/rtl/rbrk4_pkg.sv
// Shared types and constants for the rigid-body rate RK4 integrator.
// No dependencies.
package rbrk4_pkg;

    localparam int DATA_W    = 32;
    localparam int ELEM_W    = 21;
    localparam int ROW_W     = 63;
    localparam int ACC_W     = 64;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INERTIA0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INERTIA1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INERTIA2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV0      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV1      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV2      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd6;

    // operation codes for the shared multiply-accumulate unit
    typedef enum logic [1:0] {
        MAC_CLEAR = 2'd0,   // acc = a*b
        MAC_ADD   = 2'd1,   // acc += a*b
        MAC_SUB   = 2'd2    // acc -= a*b
    } mac_op_t;

    typedef struct packed {
        logic    valid;
        mac_op_t op;
    } mac_ctl_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sh7FFF_FFFF);
        lo = -ACC_W'(64'sh8000_0000);
        if (x > hi) return 32'sh7FFF_FFFF;
        if (x < lo) return 32'sh8000_0000;
        return x[DATA_W-1:0];
    endfunction

endpackage

### hw/rtl/rbrk4_mac.sv
// Shared signed 33x33 multiply-accumulate unit with a registered product.
// Depends on rbrk4_pkg.
module rbrk4_mac (
    input  logic                            aclk,
    input  rbrk4_pkg::mac_ctl_t             ctl,
    input  logic signed [32:0]              op_a,
    input  logic signed [32:0]              op_b,
    output logic signed [rbrk4_pkg::ACC_W-1:0] acc
);
    import rbrk4_pkg::*;

    logic signed [ACC_W-1:0] prod_reg;
    mac_ctl_t                ctl_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    always_ff @(posedge aclk) begin
        prod_reg <= ACC_W'(op_a * op_b);
        ctl_reg  <= ctl;
        acc_reg  <= acc_next;
    end

    always_comb begin
        acc_next = acc_reg;
        if (ctl_reg.valid) begin
            case (ctl_reg.op)
                MAC_CLEAR: acc_next = prod_reg;
                MAC_ADD:   acc_next = acc_reg + prod_reg;
                MAC_SUB:   acc_next = acc_reg - prod_reg;
                default:   acc_next = acc_reg;
            endcase
        end
    end

    assign acc = acc_reg;

endmodule

### hw/rtl/rigid_body_rate_rk4_step.sv
// Rigid-body angular-rate integrator: one RK4 step of Euler's equation per item.
// Channels: s_ item in (kind in tuser), m_ rate out, plain config write port.
// A load item only replaces the rate and shows its result the cycle after
// acceptance. An integrate item runs four derivative evaluations, each of
// 24 products plus 3 step scalings on the one shared multiplier, where each
// row waits out the MAC pipeline and then stores, and ends with the final
// sum over six (a reciprocal multiply on the same unit). s_tready is low
// from acceptance until the result has been taken, so one item is in flight.
// Reset (aresetn low, synchronous) clears the rate to zero, sets both
// matrices to identity and the step to zero. When m_tready is low the
// result is held on m_tdata until taken.
// Config must only be written while no item is in flight.
module rigid_body_rate_rk4_step #(
    parameter int MAT_FRAC_BITS  = 12,
    parameter int DATA_FRAC_BITS = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ctrl_torque_x/y/z, dist_torque_x/y/z, init_rate_x/y/z (32 bits each)
    input  logic [287:0] s_tdata,
    // kind
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rate_x, rate_y, rate_z
    output logic [95:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [rbrk4_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [62:0]  cfg_data
);
    import rbrk4_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ISSUE = 7'b0000010,
        ST_WAIT  = 7'b0000100,
        ST_STORE = 7'b0001000,
        ST_FIN   = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    // phases of one derivative evaluation
    localparam logic [2:0] PH_M = 3'd0;  // m = I*v
    localparam logic [2:0] PH_G = 3'd1;  // g = v x m
    localparam logic [2:0] PH_F = 3'd2;  // f = Iinv*t
    localparam logic [2:0] PH_K = 3'd3;  // k = f*h
    localparam logic [2:0] PH_S = 3'd4;  // final sum over 6

    // |sum| = hi*2^31 + lo and 2^31 = 6*357913941 + 2, so
    // |sum|/6 = hi*357913941 + (lo + 2*hi)/6; the last part is below 2^32
    // and 2^34/6 rounded up divides it exactly
    localparam logic signed [32:0] RECIP6 = 33'sd2863311531;
    localparam int RECIP_SH = 34;
    localparam logic [ACC_W-1:0] TWO31_DIV6 = 64'd357913941;

    state_t state_reg, state_next;

    logic [ROW_W-1:0] inertia_reg [3];
    logic [ROW_W-1:0] inv_reg [3];
    logic [DATA_W-1:0] step_reg;

    logic signed [DATA_W-1:0] rate_reg [3];
    logic signed [DATA_W:0]   tc_reg [3];  // Tc + Td, not saturated
    logic signed [DATA_W-1:0] v_reg [3];   // stage input
    logic signed [DATA_W-1:0] m_reg [3];
    logic signed [DATA_W-1:0] t_reg [3];
    logic signed [DATA_W-1:0] f_reg [3];
    logic signed [DATA_W+3:0] ksum_reg [3];
    logic signed [DATA_W+3:0] ksum_sel;
    logic signed [DATA_W+3:0] ksum_abs;
    logic [4:0]               ks_hi;
    logic [32:0]              div_in;
    logic signed [ACC_W-1:0]  gtmp_reg;

    logic [1:0] stage_reg;   // RK stage 0..3
    logic [2:0] phase_reg;
    logic [1:0] row_reg;     // output component
    logic [1:0] term_reg;    // product within a row
    logic [1:0] wait_reg;
    logic [DATA_W-1:0] outv [3];

    mac_ctl_t mac_ctl;
    logic signed [32:0] op_a, op_b;
    logic signed [ACC_W-1:0] acc;

    rbrk4_mac u_mac (
        .aclk  (aclk),
        .ctl   (mac_ctl),
        .op_a  (op_a),
        .op_b  (op_b),
        .acc   (acc)
    );

    function automatic logic signed [32:0] elem_of(input logic [ROW_W-1:0] row,
                                                   input logic [1:0] c);
        logic [ELEM_W-1:0] e;
        case (c)
            2'd0:    e = row[20:0];
            2'd1:    e = row[41:21];
            default: e = row[62:42];
        endcase
        return 33'(signed'(e));
    endfunction

    function automatic logic [1:0] nx(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    // cross product: g[r] = v[r+1]*m[r+2] - v[r+2]*m[r+1]
    logic [1:0] r1, r2;
    assign r1 = nx(row_reg);
    assign r2 = nx(r1);

    always_comb begin
        op_a = '0;
        op_b = '0;
        mac_ctl.valid = (state_reg == ST_ISSUE);
        mac_ctl.op = (term_reg == 2'd0) ? MAC_CLEAR : MAC_ADD;
        ksum_sel = ksum_reg[row_reg];
        case (phase_reg)
            PH_M: begin
                op_a = elem_of(inertia_reg[row_reg], term_reg);
                op_b = 33'(v_reg[term_reg]);
            end
            PH_G: begin
                op_a = (term_reg == 2'd0) ? 33'(v_reg[r1]) : 33'(v_reg[r2]);
                op_b = (term_reg == 2'd0) ? 33'(m_reg[r2]) : 33'(m_reg[r1]);
                mac_ctl.op = MAC_CLEAR;
            end
            PH_F: begin
                op_a = elem_of(inv_reg[row_reg], term_reg);
                op_b = 33'(t_reg[term_reg]);
            end
            PH_K: begin
                op_a = 33'(f_reg[row_reg]);
                op_b = {1'b0, step_reg};
                mac_ctl.op = MAC_CLEAR;
            end
            PH_S: begin
                op_a = div_in;
                op_b = RECIP6;
                mac_ctl.op = MAC_CLEAR;
            end
            default: ;
        endcase
    end

    assign ksum_abs = (ksum_sel < 0) ? -ksum_sel : ksum_sel;
    assign ks_hi    = ksum_abs[DATA_W+3:DATA_W-1];
    assign div_in   = 33'(ksum_abs[DATA_W-2:0]) + 33'({ks_hi, 1'b0});

    logic [1:0] last_term;
    always_comb begin
        case (phase_reg)
            PH_M, PH_F: last_term = 2'd2;
            PH_G:       last_term = 2'd1;
            default:    last_term = 2'd0;
        endcase
    end

    logic signed [ACC_W-1:0] shm, shd, gdiff;
    logic signed [ACC_W-1:0] hi_part, q6mag, q6, fin;
    assign shm = acc >>> MAT_FRAC_BITS;
    assign shd = acc >>> DATA_FRAC_BITS;
    assign gdiff = gtmp_reg - shd;
    assign hi_part = ACC_W'(ks_hi) * TWO31_DIV6;
    assign q6mag = (acc >>> RECIP_SH) + hi_part;
    assign q6 = ksum_sel < 0 ? -q6mag : q6mag;
    assign fin = ACC_W'(rate_reg[row_reg]) + q6;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = s_tuser[0] ? ST_OUT : ST_ISSUE;
            ST_ISSUE: state_next = (term_reg == last_term) ? ST_WAIT : ST_ISSUE;
            ST_WAIT:  if (wait_reg == 2'd1) state_next = ST_STORE;
            ST_STORE: state_next = (phase_reg == PH_S && row_reg == 2'd2) ? ST_OUT
                                                                          : ST_ISSUE;
            ST_FIN:   state_next = ST_OUT;
            ST_DIV:   state_next = ST_OUT;
            ST_OUT:   if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < 3; i++) begin
                inertia_reg[i] <= ROW_W'(64'd1 << (MAT_FRAC_BITS + ELEM_W * i));
                inv_reg[i]     <= ROW_W'(64'd1 << (MAT_FRAC_BITS + ELEM_W * i));
                rate_reg[i]    <= '0;
            end
            step_reg <= '0;
            stage_reg <= '0;
            phase_reg <= PH_M;
            row_reg <= '0;
            term_reg <= '0;
            wait_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_INERTIA0: inertia_reg[0] <= cfg_data;
                    REG_INERTIA1: inertia_reg[1] <= cfg_data;
                    REG_INERTIA2: inertia_reg[2] <= cfg_data;
                    REG_INV0:     inv_reg[0] <= cfg_data;
                    REG_INV1:     inv_reg[1] <= cfg_data;
                    REG_INV2:     inv_reg[2] <= cfg_data;
                    REG_STEP:     step_reg <= cfg_data[DATA_W-1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: if (s_tvalid) begin
                    for (int i = 0; i < 3; i++) begin
                        tc_reg[i] <= (DATA_W+1)'(signed'(s_tdata[32*i +: 32]))
                                     + (DATA_W+1)'(signed'(s_tdata[96+32*i +: 32]));
                        v_reg[i] <= rate_reg[i];
                        ksum_reg[i] <= '0;
                        if (s_tuser[0]) rate_reg[i] <= s_tdata[192+32*i +: 32];
                    end
                    stage_reg <= '0;
                    phase_reg <= PH_M;
                    row_reg <= '0;
                    term_reg <= '0;
                end
                ST_ISSUE: begin
                    wait_reg <= '0;
                    if (term_reg != last_term) term_reg <= term_reg + 2'd1;
                end
                ST_WAIT: wait_reg <= wait_reg + 2'd1;
                ST_STORE: begin
                    term_reg <= '0;
                    row_reg <= nx(row_reg);
                    case (phase_reg)
                        PH_M: m_reg[row_reg] <= sat32(shm);
                        PH_G: begin
                            if (last_term == 2'd1 && term_reg == 2'd1) begin
                                // second product of the pair done
                                t_reg[row_reg] <= sat32(ACC_W'(tc_reg[row_reg])
                                                  - ACC_W'(sat32(gdiff)));
                            end
                        end
                        PH_F: f_reg[row_reg] <= sat32(shm);
                        PH_K: begin
                            ksum_reg[row_reg] <= ksum_reg[row_reg] +
                                ((stage_reg == 2'd1 || stage_reg == 2'd2) ?
                                 (36'(sat32(shd)) <<< 1) : 36'(sat32(shd)));
                        end
                        PH_S: rate_reg[row_reg] <= sat32(fin);
                        default: ;
                    endcase
                    if (row_reg == 2'd2) begin
                        case (phase_reg)
                            PH_M: phase_reg <= PH_G;
                            PH_G: phase_reg <= PH_F;
                            PH_F: phase_reg <= PH_K;
                            PH_K: begin
                                if (stage_reg == 2'd3) phase_reg <= PH_S;
                                else begin
                                    phase_reg <= PH_M;
                                    stage_reg <= stage_reg + 2'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
            // next stage input once k is known
            if (state_reg == ST_STORE && phase_reg == PH_K) begin
                v_reg[row_reg] <= sat32(ACC_W'(rate_reg[row_reg]) +
                    ((stage_reg == 2'd2) ? ACC_W'(sat32(shd))
                                         : (ACC_W'(sat32(shd)) >>> 1)));
            end
        end
    end

    // the cross product uses two passes per row; gtmp holds the first term,
    // which sits in the accumulator during the first wait cycle
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WAIT && wait_reg == 2'd0 && phase_reg == PH_G)
            gtmp_reg <= shd;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) outv[i] = rate_reg[i];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {outv[2], outv[1], outv[0]};

endmodule

### hw/rtl/rbrk4_checker.sv
// Port-level checks for rigid_body_rate_rk4_step, bound to the top level.
// Depends only on the top-level ports.
module rbrk4_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);
    // one item in flight: never ready while a result waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped under stall");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("accepted while busy");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("result after reset");
endmodule

bind rigid_body_rate_rk4_step rbrk4_checker u_rbrk4_checker (.*);

### dv/rigid_body_rate_rk4_step_tb.sv
// Testbench for rigid_body_rate_rk4_step: random and directed load/integrate items with a
// bit-exact fixed-point RK4 predictor and a scoreboard on the rate output.
// Depends on rbrk4_pkg and the rigid_body_rate_rk4_step RTL.
module rigid_body_rate_rk4_step_tb;
    import rbrk4_pkg::*;

    localparam int MF = 12;
    localparam int DF = 24;
    localparam int STALL_LIMIT = 20000;

    typedef longint vec3_t [3];

    typedef struct {
        logic        kind;
        logic [31:0] tc [3];
        logic [31:0] td [3];
        logic [31:0] init [3];
    } rate_item_t;

    typedef struct {
        logic [31:0] r [3];
    } rate_out_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic         cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [62:0]  cfg_data;

    rigid_body_rate_rk4_step u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [62:0] inertia_m [3];
    logic [62:0] inv_inertia_m [3];
    logic [31:0] step_h;
    longint      body_w [3];

    rate_item_t pending_items [$];
    rate_out_t  expected_rates [$];
    rate_item_t cur_item;
    int         fails = 0;
    int         tx_gap;
    int         rx_gap;
    bit         no_idle;
    bit         long_hold_req;
    int         stall_cnt;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic vec3_t mat_mul(logic [62:0] rows [3], vec3_t a);
        vec3_t  o;
        longint acc;
        for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int c = 0; c < 3; c++)
                acc += longint'($signed(rows[r][c*21 +: 21])) * a[c];
            o[r] = sat32(acc >>> MF);
        end
        return o;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return (a * b) >>> DF;
    endfunction

    // k = h * Iinv*(Tc + Td - v x (I v)), each stage saturated
    function automatic vec3_t rk_slope(vec3_t v, vec3_t tc, vec3_t td);
        vec3_t m, g, t, f, k;
        m = mat_mul(inertia_m, v);
        g[0] = sat32(fx_mul(v[1], m[2]) - fx_mul(v[2], m[1]));
        g[1] = sat32(fx_mul(v[2], m[0]) - fx_mul(v[0], m[2]));
        g[2] = sat32(fx_mul(v[0], m[1]) - fx_mul(v[1], m[0]));
        for (int i = 0; i < 3; i++) t[i] = sat32(tc[i] + td[i] - g[i]);
        f = mat_mul(inv_inertia_m, t);
        for (int i = 0; i < 3; i++) k[i] = sat32((f[i] * longint'({32'b0, step_h})) >>> DF);
        return k;
    endfunction

    function automatic rate_out_t advance_rate(rate_item_t it);
        vec3_t     tc, td, w, k1, k2, k3, k4, st;
        rate_out_t o;
        longint    sum;
        if (it.kind) begin
            for (int i = 0; i < 3; i++) body_w[i] = longint'($signed(it.init[i]));
        end else begin
            for (int i = 0; i < 3; i++) begin
                tc[i] = longint'($signed(it.tc[i]));
                td[i] = longint'($signed(it.td[i]));
                w[i]  = body_w[i];
            end
            k1 = rk_slope(w, tc, td);
            for (int i = 0; i < 3; i++) st[i] = sat32(w[i] + (k1[i] >>> 1));
            k2 = rk_slope(st, tc, td);
            for (int i = 0; i < 3; i++) st[i] = sat32(w[i] + (k2[i] >>> 1));
            k3 = rk_slope(st, tc, td);
            for (int i = 0; i < 3; i++) st[i] = sat32(w[i] + k3[i]);
            k4 = rk_slope(st, tc, td);
            for (int i = 0; i < 3; i++) begin
                sum = k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i];
                body_w[i] = sat32(w[i] + sum / 6);
            end
        end
        for (int i = 0; i < 3; i++) o.r[i] = body_w[i][31:0];
        return o;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 65) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            tx_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_rates.push_back(advance_rate(cur_item));
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0 || pending_items.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (tx_gap > 0) tx_gap <= tx_gap - 1;
                end else begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_item.kind;
                    s_tdata  <= {cur_item.init[2], cur_item.init[1], cur_item.init[0],
                                 cur_item.td[2], cur_item.td[1], cur_item.td[0],
                                 cur_item.tc[2], cur_item.tc[1], cur_item.tc[0]};
                    tx_gap   <= pick_gap();
                end
            end
        end
    end

    // monitor and result-side stalls
    always @(posedge aclk) begin
        rate_out_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_rates.size() == 0) begin
                    $error("result item with nothing expected: %h", m_tdata);
                    fails++;
                end else begin
                    want = expected_rates.pop_front();
                    for (int i = 0; i < 3; i++)
                        if (m_tdata[32*i +: 32] !== want.r[i]) begin
                            $error("rate_%s mismatch: expected %h actual %h",
                                   i == 0 ? "x" : (i == 1 ? "y" : "z"),
                                   want.r[i], m_tdata[32*i +: 32]);
                            fails++;
                        end
                end
            end
            if (long_hold_req) begin
                m_tready <= 1'b0;
                rx_gap   <= 600;
            end else if (rx_gap > 0) begin
                m_tready <= 1'b0;
                rx_gap   <= rx_gap - 1;
            end else begin
                m_tready <= 1'b1;
                rx_gap   <= (m_tready && pick_gap() != 0) ? pick_gap() : 0;
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("** rigid_body_rate_rk4_step: FAILED **");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
            3, 4: return 32'($signed($urandom_range(0, 2 ** 26)) - 2 ** 25);
            default: return $urandom();
        endcase
    endfunction

    function automatic rate_item_t make_item(logic kind);
        rate_item_t it;
        it.kind = kind;
        for (int i = 0; i < 3; i++) begin
            it.tc[i]   = rand_word();
            it.td[i]   = rand_word();
            it.init[i] = rand_word();
        end
        return it;
    endfunction

    function automatic rate_item_t fill_item(logic kind, logic [31:0] v);
        rate_item_t it;
        it.kind = kind;
        for (int i = 0; i < 3; i++) begin
            it.tc[i] = v;
            it.td[i] = v;
            it.init[i] = v;
        end
        return it;
    endfunction

    // one matrix row; style 0 near identity, 1 moderate, 2 anything, 3 extremes
    function automatic logic [62:0] make_row(int r, int style);
        logic [62:0] row;
        logic [20:0] e;
        row[62] = $urandom_range(0, 1);
        for (int c = 0; c < 3; c++) begin
            case (style)
                0: e = (c == r) ? 21'($urandom_range(2048, 16384)) : 21'($urandom_range(0, 255));
                1: e = 21'($signed($urandom_range(0, 65536)) - 32768);
                2: e = 21'($urandom());
                default: e = $urandom_range(0, 1) ? 21'h0F_FFFF : 21'h10_0000;
            endcase
            row[c*21 +: 21] = e;
        end
        return row;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [62:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx <= REG_INERTIA2) inertia_m[idx[1:0]] = val;
        else if (idx <= REG_INV2) inv_inertia_m[2'(idx - REG_INV0)] = val;
        else if (idx == REG_STEP) step_h = val[31:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_rates.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic setup_phase(int style, logic [31:0] h);
        for (int r = 0; r < 3; r++) begin
            write_reg(REG_INERTIA0 + CFG_IDX_W'(r), make_row(r, style));
            write_reg(REG_INV0 + CFG_IDX_W'(r), make_row(r, style));
        end
        write_reg(REG_STEP, {31'b0, h});
    endtask

    initial begin
        logic [31:0] h;
        no_idle       = 1'b0;
        long_hold_req = 1'b0;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        for (int r = 0; r < 3; r++) begin
            inertia_m[r]     = 63'(64'd4096 << (21 * r));
            inv_inertia_m[r] = 63'(64'd4096 << (21 * r));
            body_w[r]        = 0;
        end
        step_h = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset config: zero step leaves the rate alone
        pending_items.push_back(fill_item(1'b0, 32'h7FFF_FFFF));
        pending_items.push_back(fill_item(1'b1, 32'h7FFF_FFFF));
        pending_items.push_back(fill_item(1'b0, 32'h8000_0000));
        pending_items.push_back(fill_item(1'b1, 32'h8000_0000));
        pending_items.push_back(fill_item(1'b1, 32'h0000_0000));
        pending_items.push_back(fill_item(1'b0, 32'h0100_0000));
        wait_idle();

        // unknown index must be ignored
        write_reg(CFG_IDX_W'(7), {63{1'b1}});
        write_reg(REG_STEP, 63'h7FFF_FFFF_0100_0000);
        pending_items.push_back(fill_item(1'b1, 32'h0100_0000));
        pending_items.push_back(fill_item(1'b0, 32'h0000_0000));
        pending_items.push_back(fill_item(1'b0, 32'h7FFF_FFFF));
        pending_items.push_back(fill_item(1'b0, 32'h8000_0000));
        pending_items.push_back(fill_item(1'b1, 32'h8000_0000));
        pending_items.push_back(fill_item(1'b0, 32'h0000_0000));
        wait_idle();

        // extreme matrices and largest step
        setup_phase(3, 32'hFFFF_FFFF);
        pending_items.push_back(fill_item(1'b1, 32'h7FFF_FFFF));
        pending_items.push_back(fill_item(1'b0, 32'h8000_0000));
        pending_items.push_back(fill_item(1'b1, 32'h8000_0000));
        pending_items.push_back(fill_item(1'b0, 32'h7FFF_FFFF));
        pending_items.push_back(make_item(1'b0));
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: h = $urandom_range(1, 1 << 20);
                1: h = $urandom_range(1 << 20, 1 << 25);
                2: h = $urandom();
                default: h = (ph == 3) ? 32'hFFFF_FFFF : 32'h0;
            endcase
            setup_phase(ph % 4, h);
            no_idle = (ph == 2);
            for (int n = 0; n < 300; n++) begin
                pending_items.push_back(make_item($urandom_range(0, 9) == 0));
                // receiver holds off while the sender keeps offering items
                if (ph == 1 && n == 150) begin
                    while (pending_items.size() != 0) @(posedge aclk);
                    long_hold_req <= 1'b1;
                    @(posedge aclk);
                    long_hold_req <= 1'b0;
                    repeat (4) pending_items.push_back(make_item(1'b0));
                end
            end
            wait_idle();
        end

        repeat (50) @(posedge aclk);
        if (fails == 0)
            $display("** rigid_body_rate_rk4_step: PASSED **");
        else
            $display("** rigid_body_rate_rk4_step: FAILED **");
        $finish;
    end

endmodule
